// ----- hw/rtl/cc20_pkg.sv -----
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the quarter-round step function for the
// ChaCha20 payload encryptor pipeline.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int unsigned DoubleRounds  = 10;
  localparam int unsigned StepsPerDRound = 8;
  localparam int unsigned NumKeyRegs    = 4;

  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646e;
  localparam logic [31:0] Sigma2 = 32'h7962_2d32;
  localparam logic [31:0] Sigma3 = 32'h6b20_6574;

  localparam logic [63:0] KeyReset01 = 64'h0706_0504_0302_0100;
  localparam logic [63:0] KeyReset23 = 64'h0F0E_0D0C_0B0A_0908;
  localparam logic [63:0] KeyReset45 = 64'h1716_1514_1312_1110;
  localparam logic [63:0] KeyReset67 = 64'h1F1E_1D1C_1B1A_1918;

  typedef enum logic [1:0] {
    RegKey01 = 2'd0,
    RegKey23 = 2'd1,
    RegKey45 = 2'd2,
    RegKey67 = 2'd3
  } cc20_reg_e;

  typedef logic [15:0][31:0] cc20_state_t;

  // one item in flight: working state, payload and per-byte keep mask
  typedef struct packed {
    cc20_state_t   st;
    logic [127:0]  plain;
    logic [15:0]   keep;
  } cc20_item_t;

  // one dependent add/xor/rotate step on all four quarter-round lanes
  // k[2] selects the diagonal round, k[1:0] the step inside the quarter round
  function automatic cc20_state_t cc20_step(cc20_state_t s, logic [2:0] k);
    cc20_state_t r;
    logic [1:0]  jj;
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] x;
    r = s;
    for (int j = 0; j < 4; j++) begin
      jj = j[1:0];
      ia = {2'd0, jj};
      ib = {2'd1, k[2] ? jj + 2'd1 : jj};
      ic = {2'd2, k[2] ? jj + 2'd2 : jj};
      id = {2'd3, k[2] ? jj + 2'd3 : jj};
      case (k[1:0])
        2'd0: begin
          r[ia] = r[ia] + r[ib];
          x = r[id] ^ r[ia];
          r[id] = {x[15:0], x[31:16]};
        end
        2'd1: begin
          r[ic] = r[ic] + r[id];
          x = r[ib] ^ r[ic];
          r[ib] = {x[19:0], x[31:20]};
        end
        2'd2: begin
          r[ia] = r[ia] + r[ib];
          x = r[id] ^ r[ia];
          r[id] = {x[23:0], x[31:24]};
        end
        default: begin
          r[ic] = r[ic] + r[id];
          x = r[ib] ^ r[ic];
          r[ib] = {x[24:0], x[31:25]};
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/cc20_dround.sv -----
// ----------------------------------------------------------------------------
// cc20_dround
// One double round (column round then diagonal round) as eight register
// stages, one add/xor/rotate step on all four lanes per stage.
// ----------------------------------------------------------------------------
module cc20_dround
  import cc20_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  cc20_item_t item_i,
  output logic       valid_o,
  output cc20_item_t item_o
);

  logic       valid_q [StepsPerDRound+1];
  cc20_item_t item_q  [StepsPerDRound+1];

  assign valid_q[0] = valid_i;
  assign item_q[0]  = item_i;

  for (genvar k = 0; k < StepsPerDRound; k++) begin : g_step
    cc20_item_t item_d;

    always_comb begin
      item_d    = item_q[k];
      item_d.st = cc20_step(item_q[k].st, 3'(k));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k+1] <= item_d;
      end
    end
  end

  assign valid_o = valid_q[StepsPerDRound];
  assign item_o  = item_q[StepsPerDRound];

endmodule

// ----- hw/rtl/cc20_finalize.sv -----
// ----------------------------------------------------------------------------
// cc20_finalize
// Adds the constant words back, XORs the keystream with the payload, zeroes
// bytes past the count and holds the result in the output register.
// ----------------------------------------------------------------------------
module cc20_finalize
  import cc20_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  cc20_item_t   item_i,
  output logic         valid_o,
  output logic [127:0] cipher_o
);

  logic [3:0][31:0] ks;
  logic [127:0]     keep_bits;
  logic [127:0]     cipher_d;
  logic [127:0]     cipher_q;
  logic             valid_q;

  // only words 0..3 are used, and their input words are the constants
  assign ks[0] = item_i.st[0] + Sigma0;
  assign ks[1] = item_i.st[1] + Sigma1;
  assign ks[2] = item_i.st[2] + Sigma2;
  assign ks[3] = item_i.st[3] + Sigma3;

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      keep_bits[8*b +: 8] = {8{item_i.keep[b]}};
    end
  end

  assign cipher_d = (item_i.plain ^ ks) & keep_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cipher_q <= cipher_d;
    end
  end

  assign valid_o  = valid_q;
  assign cipher_o = cipher_q;

endmodule

// ----- hw/rtl/chacha20_payload_encrypt.sv -----
// ----------------------------------------------------------------------------
// chacha20_payload_encrypt
// ChaCha20 keystream block over a sequence-number nonce, XORed with a 16-byte
// payload; bytes at or past the count are zeroed. Fully pipelined rounds.
//
//   channel   dir  width  contents
//   s_axis    in   200    nonce, plain_low, plain_high, valid_bytes
//   m_axis    out  128    cipher_low, cipher_high
//   cfg       in   64     key register writes, index 0..3
//
// one item per cycle unless stalled; an input register, the round pipeline of
// one add/xor/rotate step per stage and the output register lie in the path.
// all stages move together; a held result stalls the whole pipeline, and
// s_axis_tready drops only while m_axis_tvalid is high and m_axis_tready low.
// reset clears all valid bits and loads the default key; no clearing pass.
// ----------------------------------------------------------------------------
module chacha20_payload_encrypt
  import cc20_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // nonce[63:0], plain_low[127:64], plain_high[191:128], valid_bytes[196:192]
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cipher_low[63:0], cipher_high[127:64]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  logic [NumKeyRegs-1:0][63:0] key_q;
  logic                        en;
  logic                        in_valid_q;
  cc20_item_t                  in_item_d, in_item_q;
  logic [4:0]                  vbytes;

  logic       dr_valid [DoubleRounds+1];
  cc20_item_t dr_item  [DoubleRounds+1];

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KeyReset01;
      key_q[1] <= KeyReset23;
      key_q[2] <= KeyReset45;
      key_q[3] <= KeyReset67;
    end else if (cfg_we_i) begin
      unique case (cc20_reg_e'(cfg_idx_i))
        RegKey01: key_q[0] <= cfg_data_i;
        RegKey23: key_q[1] <= cfg_data_i;
        RegKey45: key_q[2] <= cfg_data_i;
        RegKey67: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign vbytes        = s_axis_tdata[196:192];

  // initial state, payload and byte keep mask
  always_comb begin
    in_item_d.st[0]  = Sigma0;
    in_item_d.st[1]  = Sigma1;
    in_item_d.st[2]  = Sigma2;
    in_item_d.st[3]  = Sigma3;
    for (int i = 0; i < NumKeyRegs; i++) begin
      in_item_d.st[4 + 2*i] = key_q[i][31:0];
      in_item_d.st[5 + 2*i] = key_q[i][63:32];
    end
    in_item_d.st[12] = 32'd0;
    in_item_d.st[13] = 32'd0;
    in_item_d.st[14] = s_axis_tdata[31:0];
    in_item_d.st[15] = s_axis_tdata[63:32];
    in_item_d.plain  = s_axis_tdata[191:64];
    for (int b = 0; b < 16; b++) begin
      in_item_d.keep[b] = (5'(b) < vbytes);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_item_q <= in_item_d;
    end
  end

  assign dr_valid[0] = in_valid_q;
  assign dr_item[0]  = in_item_q;

  for (genvar r = 0; r < DoubleRounds; r++) begin : g_dround
    cc20_dround u_dround (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dr_valid[r]),
      .item_i  (dr_item[r]),
      .valid_o (dr_valid[r+1]),
      .item_o  (dr_item[r+1])
    );
  end

  cc20_finalize u_finalize (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (dr_valid[DoubleRounds]),
    .item_i   (dr_item[DoubleRounds]),
    .valid_o  (m_axis_tvalid),
    .cipher_o (m_axis_tdata)
  );

  // a key write lands in the addressed register
  a_key_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> key_q[$past(cfg_idx_i)] == $past(cfg_data_i))
    else $error("key register write lost");

  // a stalled result holds its data through the pipeline freeze
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("held result changed");

  // the first stage freezes together with the output register
  a_front_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> in_valid_q == $past(in_valid_q))
    else $error("input stage moved during stall");

endmodule
